// ===== hdl/swms_pkg.sv =====
// ----------------------------------------------------------------------------
// swms_pkg: shared types and constants
// Window geometry, derived arithmetic widths, request codes and the beat
// structs that pass between the front queue, the back end and the top level.
// ----------------------------------------------------------------------------
package swms_pkg;

   localparam int DEPTH    = 32;                 // ring slots
   localparam int CH       = 3;                  // channels per sample
   localparam int SMP_W    = 16;                 // Q8.8 sample
   localparam int IDX_W    = $clog2(DEPTH);      // slot index / read offset
   localparam int CNT_W    = IDX_W + 1;          // count and window length
   localparam int SUM_W    = SMP_W + IDX_W;      // signed running sum
   localparam int SQ_W     = 2 * SMP_W;          // one square
   localparam int SSUM_W   = SQ_W - 1 + IDX_W;   // running sum of squares
   localparam int D_W      = CNT_W + SSUM_W;     // n*ssum - sum^2
   localparam int R_W      = D_W / 2;            // square root / divider width
   localparam int STEP_W   = $clog2(R_W);

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_READ = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef logic [CH-1:0][SMP_W-1:0] sample_vec_type;

   // one classified request in the queue
   typedef struct packed {
      op_type          op;
      sample_vec_type  smp;
      logic [IDX_W-1:0] offset;
   } req_entry_type;

   // one result beat
   typedef struct packed {
      sample_vec_type   mean;
      sample_vec_type   std;
      sample_vec_type   entry;
      logic [CNT_W-1:0] fill_count;
      logic             is_full;
   } rsp_beat_type;

   // map a written length onto 1..DEPTH
   function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > CNT_W'(DEPTH)) begin
         r = CNT_W'(DEPTH);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== hdl/swms_front.sv =====
// ----------------------------------------------------------------------------
// swms_front: request intake
// Classifies request beats and holds them in a two-entry queue so the input
// side keeps flowing while the back end is busy, until both entries fill.
// ----------------------------------------------------------------------------
module swms_front import swms_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_type,
   input  logic signed [SMP_W-1:0] req_sample_ch0,
   input  logic signed [SMP_W-1:0] req_sample_ch1,
   input  logic signed [SMP_W-1:0] req_sample_ch2,
   input  logic [IDX_W-1:0]        req_read_offset,
   output logic                    q_valid,
   input  logic                    q_pop,
   output req_entry_type           q_data
);

   req_entry_type q_ff [2];
   logic          wr_ptr_ff;
   logic          rd_ptr_ff;
   logic [1:0]    cnt_ff;
   req_entry_type entry_in;
   logic          push;
   logic          pop;

   // classify the beat
   always_comb begin
      entry_in.smp    = {req_sample_ch2, req_sample_ch1, req_sample_ch0};
      entry_in.offset = req_read_offset;
      unique case (op_type'(req_type))
         OP_PUSH: entry_in.op = OP_PUSH;
         OP_POP:  entry_in.op = OP_POP;
         OP_READ: entry_in.op = OP_READ;
         default: entry_in.op = OP_NOP;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_data    = q_ff[rd_ptr_ff];

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry_in;
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule

// ===== hdl/swms_lane.sv =====
// ----------------------------------------------------------------------------
// swms_lane: per-channel statistics
// Mean by restoring division, then std as isqrt(n*ssum - sum^2) / n, with
// one square-root unit and one divider stepping a bit per cycle.
// ----------------------------------------------------------------------------
module swms_lane import swms_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [CNT_W-1:0]         n,
   input  logic signed [SUM_W-1:0]  s,
   input  logic [SSUM_W-1:0]        ss,
   output logic                     busy,
   output logic [SMP_W-1:0]         mean,
   output logic [SMP_W-1:0]         std
);

   typedef enum logic [2:0] {
      L_IDLE, L_MUL, L_SUB, L_ROOT, L_MEAN, L_DIV, L_FIN
   } lstate_type;

   lstate_type              state_ff;
   logic [CNT_W-1:0]        n_ff;
   logic signed [SUM_W-1:0] s_ff;
   logic [SSUM_W-1:0]       ss_ff;
   logic [D_W-1:0]          pa_ff;
   logic [D_W-1:0]          pb_ff;
   logic [D_W-1:0]          v_ff;
   logic [D_W-1:0]          res_ff;
   logic [D_W-1:0]          bit_ff;
   logic [R_W-1:0]          quot_ff;
   logic [CNT_W-1:0]        rem_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [SMP_W-1:0]        mean_ff;
   logic [SMP_W-1:0]        std_ff;

   logic [D_W-1:0]          prod_a;
   logic signed [D_W-1:0]   prod_b;
   logic [D_W:0]            diff;
   logic [D_W-1:0]          trial;
   logic                    root_ge;
   logic [D_W-1:0]          v_in;
   logic [D_W-1:0]          res_in;
   logic [CNT_W:0]          shifted;
   logic                    div_ge;
   logic [CNT_W:0]          rem_wide;
   logic [CNT_W-1:0]        rem_in;
   logic [R_W-1:0]          quot_in;
   logic [R_W-1:0]          s_abs;
   logic [R_W-1:0]          mean_q;
   logic                    last_step;

   // products, one multiplier each, registered
   assign prod_a = n_ff * ss_ff;
   assign prod_b = s_ff * s_ff;
   assign diff   = {1'b0, pa_ff} - {1'b0, pb_ff};

   // one square-root step
   assign trial   = res_ff + bit_ff;
   assign root_ge = (v_ff >= trial);
   assign v_in    = root_ge ? (v_ff - trial) : v_ff;
   assign res_in  = root_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);

   // one restoring division step
   assign shifted  = {rem_ff, quot_ff[R_W-1]};
   assign div_ge   = (shifted >= {1'b0, n_ff});
   assign rem_wide = div_ge ? (shifted - {1'b0, n_ff}) : shifted;
   assign rem_in   = rem_wide[CNT_W-1:0];
   assign quot_in  = {quot_ff[R_W-2:0], div_ge};

   assign s_abs     = s_ff[SUM_W-1] ? R_W'(-s_ff) : R_W'(s_ff);
   assign mean_q    = s_ff[SUM_W-1] ? (~quot_ff + R_W'(1)) : quot_ff;
   assign last_step = (step_ff == STEP_W'(R_W - 1));

   assign busy = (state_ff != L_IDLE);
   assign mean = mean_ff;
   assign std  = std_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         unique case (state_ff)
            L_IDLE: begin
               if (start) begin
                  n_ff     <= n;
                  s_ff     <= s;
                  ss_ff    <= ss;
                  state_ff <= L_MUL;
               end
            end
            L_MUL: begin
               pa_ff    <= prod_a;
               pb_ff    <= unsigned'(prod_b);
               state_ff <= L_SUB;
            end
            L_SUB: begin
               // negative difference clamps to zero
               v_ff     <= diff[D_W] ? '0 : diff[D_W-1:0];
               res_ff   <= '0;
               bit_ff   <= D_W'(1) << (D_W - 2);
               quot_ff  <= s_abs;
               rem_ff   <= '0;
               step_ff  <= '0;
               state_ff <= L_ROOT;
            end
            L_ROOT: begin
               v_ff    <= v_in;
               res_ff  <= res_in;
               bit_ff  <= bit_ff >> 2;
               quot_ff <= quot_in;
               rem_ff  <= rem_in;
               step_ff <= step_ff + STEP_W'(1);
               if (last_step) state_ff <= L_MEAN;
            end
            L_MEAN: begin
               mean_ff  <= mean_q[SMP_W-1:0];
               quot_ff  <= res_ff[R_W-1:0];
               rem_ff   <= '0;
               step_ff  <= '0;
               state_ff <= L_DIV;
            end
            L_DIV: begin
               quot_ff <= quot_in;
               rem_ff  <= rem_in;
               step_ff <= step_ff + STEP_W'(1);
               if (last_step) state_ff <= L_FIN;
            end
            L_FIN: begin
               // empty window reads as zero
               if (n_ff == '0) begin
                  mean_ff <= '0;
                  std_ff  <= '0;
               end else begin
                  std_ff  <= quot_ff[SMP_W-1:0];
               end
               state_ff <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/swms_back.sv =====
// ----------------------------------------------------------------------------
// swms_back: window execution
// Owns the sample ring, pointers, count and running sums; executes one queued
// request at a time, starts the channel lanes and holds the result beat.
// ----------------------------------------------------------------------------
module swms_back import swms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CNT_W-1:0]  csr_window_length,
   input  logic              q_valid,
   input  req_entry_type     q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_beat_type      rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_OLD_SQ, S_OLD_SUB, S_NEW_SQ, S_NEW_ADD,
      S_READ_WAIT, S_STATS, S_WAIT
   } state_type;

   state_type               state_ff;
   req_entry_type           cur_ff;
   logic [CNT_W-1:0]        len_ff;
   logic [IDX_W-1:0]        oldest_ff;
   logic [IDX_W-1:0]        newest_ff;
   logic [CNT_W-1:0]        count_ff;
   logic signed [SUM_W-1:0] sum_ff  [CH];
   logic [SSUM_W-1:0]       ssum_ff [CH];
   logic signed [SMP_W-1:0] val_ff  [CH];
   logic [SQ_W-1:0]         sq_ff   [CH];
   sample_vec_type          entry_ff;
   sample_vec_type          rd_data_ff;
   sample_vec_type          mem_ff [DEPTH];
   rsp_beat_type            rsp_ff;
   logic                    rsp_valid_ff;

   logic [IDX_W-1:0]        rd_addr;
   logic [CNT_W-1:0]        slot_sum;
   logic [CNT_W-1:0]        slot_wrap;
   logic [IDX_W-1:0]        oldest_next;
   logic [IDX_W-1:0]        newest_next;
   logic [CNT_W-1:0]        csr_len;
   logic                    lane_start;
   logic [CH-1:0]           lane_busy;
   sample_vec_type          lane_mean;
   sample_vec_type          lane_std;
   logic                    rsp_free;
   logic                    rsp_load;

   // square of one signed sample, sign-extended before the multiply
   function automatic logic [SQ_W-1:0] square_q(input logic signed [SMP_W-1:0] v);
      logic signed [SQ_W-1:0] w;
      w = SQ_W'(v);
      return unsigned'(w * w);
   endfunction

   assign csr_ready  = (state_ff == S_IDLE);
   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign lane_start = (state_ff == S_STATS);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = (state_ff == S_WAIT) && (lane_busy == '0) && rsp_free;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_len    = eff_len(csr_window_length);

   // ring arithmetic, pointers always stay below the length
   assign slot_sum    = {1'b0, oldest_ff} + {1'b0, cur_ff.offset};
   assign slot_wrap   = (slot_sum >= len_ff) ? (slot_sum - len_ff) : slot_sum;
   assign oldest_next = ({1'b0, oldest_ff} + CNT_W'(1) == len_ff) ? '0
                                                         : oldest_ff + IDX_W'(1);
   assign newest_next = ({1'b0, newest_ff} + CNT_W'(1) == len_ff) ? '0
                                                         : newest_ff + IDX_W'(1);
   assign rd_addr     = (cur_ff.op == OP_READ) ? slot_wrap[IDX_W-1:0] : oldest_ff;

   // sample ring, registered read
   always_ff @(posedge clock) begin
      if (state_ff == S_NEW_SQ) begin
         mem_ff[newest_next] <= cur_ff.smp;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // channel lanes
   for (genvar c = 0; c < CH; c++) begin : g_lane
      swms_lane u_lane (
         .clock (clock),
         .reset (reset),
         .start (lane_start),
         .n     (count_ff),
         .s     (sum_ff[c]),
         .ss    (ssum_ff[c]),
         .busy  (lane_busy[c]),
         .mean  (lane_mean[c]),
         .std   (lane_std[c])
      );
   end

   // request sequencer and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= CNT_W'(DEPTH);
         oldest_ff    <= '0;
         newest_ff    <= IDX_W'(DEPTH - 1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CH; c++) begin
            sum_ff[c]  <= '0;
            ssum_ff[c] <= '0;
         end
      end else begin
         // result held until taken, reloaded when the lanes finish
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);

         // length write empties the window
         if (csr_valid && csr_ready) begin
            len_ff    <= csr_len;
            oldest_ff <= '0;
            newest_ff <= IDX_W'(csr_len - CNT_W'(1));
            count_ff  <= '0;
            for (int c = 0; c < CH; c++) begin
               sum_ff[c]  <= '0;
               ssum_ff[c] <= '0;
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_ff   <= q_data;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               entry_ff <= '0;
               unique case (cur_ff.op)
                  OP_PUSH: state_ff <= (count_ff >= len_ff) ? S_OLD_SQ : S_NEW_SQ;
                  OP_POP:  state_ff <= (count_ff != '0) ? S_OLD_SQ : S_STATS;
                  OP_READ: state_ff <= ({1'b0, cur_ff.offset} < count_ff) ? S_READ_WAIT
                                                                            : S_STATS;
                  default: state_ff <= S_STATS;
               endcase
            end
            S_OLD_SQ: begin
               for (int c = 0; c < CH; c++) begin
                  val_ff[c] <= rd_data_ff[c];
                  sq_ff[c]  <= square_q(rd_data_ff[c]);
               end
               state_ff <= S_OLD_SUB;
            end
            S_OLD_SUB: begin
               for (int c = 0; c < CH; c++) begin
                  sum_ff[c]  <= sum_ff[c] - SUM_W'(val_ff[c]);
                  ssum_ff[c] <= ssum_ff[c] - SSUM_W'(sq_ff[c]);
               end
               oldest_ff <= oldest_next;
               count_ff  <= count_ff - CNT_W'(1);
               state_ff  <= (cur_ff.op == OP_PUSH) ? S_NEW_SQ : S_STATS;
            end
            S_NEW_SQ: begin
               for (int c = 0; c < CH; c++) begin
                  val_ff[c] <= cur_ff.smp[c];
                  sq_ff[c]  <= square_q(cur_ff.smp[c]);
               end
               newest_ff <= newest_next;
               state_ff  <= S_NEW_ADD;
            end
            S_NEW_ADD: begin
               for (int c = 0; c < CH; c++) begin
                  sum_ff[c]  <= sum_ff[c] + SUM_W'(val_ff[c]);
                  ssum_ff[c] <= ssum_ff[c] + SSUM_W'(sq_ff[c]);
               end
               count_ff <= count_ff + CNT_W'(1);
               state_ff <= S_STATS;
            end
            S_READ_WAIT: begin
               entry_ff <= rd_data_ff;
               state_ff <= S_STATS;
            end
            S_STATS: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (rsp_load) begin
                  rsp_ff.mean       <= lane_mean;
                  rsp_ff.std        <= lane_std;
                  rsp_ff.entry      <= entry_ff;
                  rsp_ff.fill_count <= count_ff;
                  rsp_ff.is_full    <= (count_ff == len_ff);
                  state_ff          <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/sliding_window_mean_std.sv =====
// ----------------------------------------------------------------------------
// sliding_window_mean_std: windowed mean and deviation, three channels
// Ring window of Q8.8 samples with per-channel running sum and sum of squares.
//
// Request channel (req_valid / req_stall): push, drop oldest, read at an
// offset, or no-op. Beats enter a two-entry queue, so intake goes on while
// the back end works. Result channel (rsp_valid / rsp_stall): one beat per
// request, in order: means, deviations, read entry, fill count, full flag.
// Config channel (csr_valid / csr_ready): window length, 0 acts as 1 and
// values above 32 act as 32; a write empties the window. Write only when idle.
// A request is dequeued (S_IDLE) and decoded (S_DECODE), updates the window
// (evict in S_OLD_SQ, S_OLD_SUB, then insert in S_NEW_SQ, S_NEW_ADD), starts
// the lanes (S_STATS) and waits (S_WAIT). Each lane runs setup (L_MUL, L_SUB),
// the 21-step square root with the mean divide alongside, the 21-step std
// divide and a finishing state (L_FIN); the result register loads once all
// lanes are idle and the output is free. One request is processed at a time.
// A stalled result holds in the output register; the back end waits on it
// and the queue fills, after which req_stall rises.
// Synchronous reset empties the window and sets the length to 32; sample
// memory contents are not cleared.
// ----------------------------------------------------------------------------
module sliding_window_mean_std import swms_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_type,
   input  logic signed [SMP_W-1:0] req_sample_ch0,
   input  logic signed [SMP_W-1:0] req_sample_ch1,
   input  logic signed [SMP_W-1:0] req_sample_ch2,
   input  logic [IDX_W-1:0]        req_read_offset,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SMP_W-1:0] rsp_mean_ch0,
   output logic signed [SMP_W-1:0] rsp_mean_ch1,
   output logic signed [SMP_W-1:0] rsp_mean_ch2,
   output logic [SMP_W-1:0]        rsp_std_ch0,
   output logic [SMP_W-1:0]        rsp_std_ch1,
   output logic [SMP_W-1:0]        rsp_std_ch2,
   output logic signed [SMP_W-1:0] rsp_entry_ch0,
   output logic signed [SMP_W-1:0] rsp_entry_ch1,
   output logic signed [SMP_W-1:0] rsp_entry_ch2,
   output logic [CNT_W-1:0]        rsp_fill_count,
   output logic                    rsp_is_full,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CNT_W-1:0]        csr_window_length
);

   logic          q_valid;
   logic          q_pop;
   req_entry_type q_data;
   rsp_beat_type  rsp_data;

   swms_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_sample_ch0  (req_sample_ch0),
      .req_sample_ch1  (req_sample_ch1),
      .req_sample_ch2  (req_sample_ch2),
      .req_read_offset (req_read_offset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_data          (q_data)
   );

   swms_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length),
      .q_valid           (q_valid),
      .q_data            (q_data),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data)
   );

   // unpack result beat
   assign rsp_mean_ch0   = rsp_data.mean[0];
   assign rsp_mean_ch1   = rsp_data.mean[1];
   assign rsp_mean_ch2   = rsp_data.mean[2];
   assign rsp_std_ch0    = rsp_data.std[0];
   assign rsp_std_ch1    = rsp_data.std[1];
   assign rsp_std_ch2    = rsp_data.std[2];
   assign rsp_entry_ch0  = rsp_data.entry[0];
   assign rsp_entry_ch1  = rsp_data.entry[1];
   assign rsp_entry_ch2  = rsp_data.entry[2];
   assign rsp_fill_count = rsp_data.fill_count;
   assign rsp_is_full    = rsp_data.is_full;

   // empty window reports zero statistics
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fill_count == '0) |->
         (rsp_mean_ch0 == '0) && (rsp_mean_ch1 == '0) && (rsp_mean_ch2 == '0) &&
         (rsp_std_ch0 == '0) && (rsp_std_ch1 == '0) && (rsp_std_ch2 == '0))
      else $error("nonzero statistics for empty window");

   // window length is at least one, so empty is never full
   a_empty_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fill_count == '0) |-> !rsp_is_full)
      else $error("empty window flagged full");

   // count never exceeds the ring
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fill_count <= CNT_W'(DEPTH)))
      else $error("fill count beyond depth");

endmodule

// ===== dv/swms_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swms_checker: window statistics predictor and result comparator
// Watches the request, result and length-write channels, keeps its own copy
// of the sample window, predicts each result beat and compares field by field.
// ----------------------------------------------------------------------------
module swms_checker import swms_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [1:0]              req_type,
   input  logic signed [SMP_W-1:0] req_sample_ch0,
   input  logic signed [SMP_W-1:0] req_sample_ch1,
   input  logic signed [SMP_W-1:0] req_sample_ch2,
   input  logic [IDX_W-1:0]        req_read_offset,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [SMP_W-1:0] rsp_mean_ch0,
   input  logic signed [SMP_W-1:0] rsp_mean_ch1,
   input  logic signed [SMP_W-1:0] rsp_mean_ch2,
   input  logic [SMP_W-1:0]        rsp_std_ch0,
   input  logic [SMP_W-1:0]        rsp_std_ch1,
   input  logic [SMP_W-1:0]        rsp_std_ch2,
   input  logic signed [SMP_W-1:0] rsp_entry_ch0,
   input  logic signed [SMP_W-1:0] rsp_entry_ch1,
   input  logic signed [SMP_W-1:0] rsp_entry_ch2,
   input  logic [CNT_W-1:0]        rsp_fill_count,
   input  logic                    rsp_is_full,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CNT_W-1:0]        csr_window_length,
   output int                      fail_count,
   output int                      pending_count
);

   // predictor state
   logic signed [SMP_W-1:0] win_mem [DEPTH][CH];
   int unsigned             head_slot, tail_slot, fill, win_len;
   longint                  sum_acc [CH];
   longint                  sq_acc [CH];
   rsp_beat_type            expected_beats [$];

   assign pending_count = expected_beats.size();

   function automatic longint int_sqrt(input longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   task automatic clear_window();
      head_slot = 0;
      tail_slot = win_len - 1;
      fill = 0;
      for (int c = 0; c < CH; c++) begin
         sum_acc[c] = 0;
         sq_acc[c] = 0;
      end
   endtask

   task automatic drop_head();
      longint v;
      if (fill != 0) begin
         for (int c = 0; c < CH; c++) begin
            v = win_mem[head_slot][c];
            sum_acc[c] -= v;
            sq_acc[c] -= v * v;
         end
         head_slot = (head_slot + 1) % win_len;
         fill--;
      end
   endtask

   // apply one request beat and queue the resulting statistics
   task automatic apply_request(input op_type op, input sample_vec_type smp,
                                input int unsigned offs);
      rsp_beat_type b;
      longint       n, s, d;
      int unsigned  slot;
      b = '0;
      case (op)
         OP_PUSH: begin
            if (fill >= win_len) drop_head();
            tail_slot = (tail_slot + 1) % win_len;
            for (int c = 0; c < CH; c++) begin
               win_mem[tail_slot][c] = smp[c];
               sum_acc[c] += longint'($signed(smp[c]));
               sq_acc[c] += longint'($signed(smp[c])) * longint'($signed(smp[c]));
            end
            fill++;
         end
         OP_POP: drop_head();
         OP_READ: begin
            if (offs < fill) begin
               slot = (head_slot + offs) % win_len;
               for (int c = 0; c < CH; c++) b.entry[c] = win_mem[slot][c];
            end
         end
         default: ;
      endcase
      for (int c = 0; c < CH; c++) begin
         if (fill != 0) begin
            n = fill;
            s = sum_acc[c];
            d = n * sq_acc[c] - s * s;
            b.mean[c] = SMP_W'(s / n);
            b.std[c] = SMP_W'(((d > 0) ? int_sqrt(d) : 64'sd0) / n);
         end
      end
      b.fill_count = CNT_W'(fill);
      b.is_full = (fill == win_len);
      expected_beats.push_back(b);
   endtask

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // sample all three channels at the rising edge
   always @(posedge clock) begin
      rsp_beat_type want, got;
      if (reset) begin
         win_len = DEPTH;
         clear_window();
         expected_beats.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            win_len = eff_len(csr_window_length);
            clear_window();
         end
         if (rsp_valid && !rsp_stall) begin
            got.mean = {rsp_mean_ch2, rsp_mean_ch1, rsp_mean_ch0};
            got.std = {rsp_std_ch2, rsp_std_ch1, rsp_std_ch0};
            got.entry = {rsp_entry_ch2, rsp_entry_ch1, rsp_entry_ch0};
            got.fill_count = rsp_fill_count;
            got.is_full = rsp_is_full;
            if (expected_beats.size() == 0) begin
               $display("%0t: result beat with nothing expected", $realtime);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               for (int c = 0; c < CH; c++) begin
                  if (got.mean[c] !== want.mean[c])
                     report_mismatch($sformatf("mean_ch%0d", c), got.mean[c], want.mean[c]);
                  if (got.std[c] !== want.std[c])
                     report_mismatch($sformatf("std_ch%0d", c), got.std[c], want.std[c]);
                  if (got.entry[c] !== want.entry[c])
                     report_mismatch($sformatf("entry_ch%0d", c), got.entry[c],
                                     want.entry[c]);
               end
               if (got.fill_count !== want.fill_count)
                  report_mismatch("fill_count", got.fill_count, want.fill_count);
               if (got.is_full !== want.is_full)
                  report_mismatch("is_full", got.is_full, want.is_full);
            end
         end
         if (req_valid && !req_stall)
            apply_request(op_type'(req_type),
                          {req_sample_ch2, req_sample_ch1, req_sample_ch0},
                          req_read_offset);
      end
   end

endmodule

// ===== dv/tb_sliding_window_mean_std.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_mean_std: window statistics regression
// Drives directed and random push, drop, read and no-op beats under several
// idle and stall mixes and window lengths; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_sliding_window_mean_std;
   import swms_pkg::*;

   localparam int MAX_CYCLES = 3_000_000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_type = '0;
   logic signed [SMP_W-1:0] req_sample_ch0 = '0;
   logic signed [SMP_W-1:0] req_sample_ch1 = '0;
   logic signed [SMP_W-1:0] req_sample_ch2 = '0;
   logic [IDX_W-1:0]        req_read_offset = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [SMP_W-1:0] rsp_mean_ch0, rsp_mean_ch1, rsp_mean_ch2;
   logic [SMP_W-1:0]        rsp_std_ch0, rsp_std_ch1, rsp_std_ch2;
   logic signed [SMP_W-1:0] rsp_entry_ch0, rsp_entry_ch1, rsp_entry_ch2;
   logic [CNT_W-1:0]        rsp_fill_count;
   logic                    rsp_is_full;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CNT_W-1:0]        csr_window_length = '0;
   int                      fail_count, pending_count;
   int                      send_idle_pct = 0;
   int                      stall_pct = 0;
   int                      cycle_count = 0;
   int                      push_pct = 60;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sliding_window_mean_std DUT (.*);

   swms_checker u_checker (.*);

   // receiver stall, changed at the falling edge
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLES) begin
         $display("sliding_window_mean_std regression: fail");
         $finish;
      end
   end

   // send one request beat, holding it until accepted; valid stays high after
   // acceptance until the next beat or an idle cycle replaces it
   task automatic send_beat(input op_type op, input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] c, input logic [IDX_W-1:0] offs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_sample_ch0 <= a;
      req_sample_ch1 <= b;
      req_sample_ch2 <= c;
      req_read_offset <= offs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      int unsigned k;
      logic [15:0] v [3];
      k = $urandom_range(99);
      for (int c = 0; c < 3; c++) begin
         case ($urandom_range(3))
            0: v[c] = $urandom;
            1: v[c] = $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: v[c] = 16'(int'($urandom_range(1024)) - 512);
         endcase
      end
      if (k < push_pct)
         send_beat(OP_PUSH, v[0], v[1], v[2], $urandom);
      else if (k < push_pct + 15)
         send_beat(OP_POP, v[0], v[1], v[2], $urandom);
      else if (k < 97)
         send_beat(OP_READ, v[0], v[1], v[2], $urandom);
      else
         send_beat(OP_NOP, v[0], v[1], v[2], $urandom);
   endtask

   // wait until the window is quiet, then write a new length
   task automatic write_length(input logic [CNT_W-1:0] len);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_valid <= 1'b1;
      csr_window_length <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_idle [4] = '{0, 58, 0, 20};
      int phase_stall [4] = '{0, 0, 58, 20};
      logic [CNT_W-1:0] lengths [4] = '{6'd32, 6'd1, 6'd0, 6'd63};
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty window cases, extremes, full window wrap
      send_beat(OP_POP, 0, 0, 0, 0);
      send_beat(OP_READ, 0, 0, 0, 0);
      send_beat(OP_NOP, 16'hffff, 16'hffff, 16'hffff, 5'h1f);
      send_beat(OP_PUSH, 16'h7fff, 16'h8000, 16'h0000, 5'h1f);
      send_beat(OP_PUSH, 16'h8000, 16'h7fff, 16'hffff, 0);
      send_beat(OP_READ, 0, 0, 0, 1);
      send_beat(OP_READ, 0, 0, 0, 2);
      send_beat(OP_READ, 0, 0, 0, 5'h1f);
      send_beat(OP_POP, 0, 0, 0, 0);
      send_beat(OP_POP, 0, 0, 0, 0);
      send_beat(OP_POP, 0, 0, 0, 0);
      write_length(6'd3);
      for (int i = 0; i < 5; i++) send_beat(OP_PUSH, 16'(i * 300), -16'(i * 77), 16'h8000, 0);
      send_beat(OP_READ, 0, 0, 0, 0);
      send_beat(OP_READ, 0, 0, 0, 2);
      send_beat(OP_READ, 0, 0, 0, 3);

      // random phases across lengths and idle mixes
      for (int p = 0; p < 8; p++) begin
         write_length(p < 4 ? lengths[p] : 6'($urandom_range(63)));
         send_idle_pct = phase_idle[p % 4];
         stall_pct = phase_stall[p % 4];
         push_pct = (p % 2) ? 45 : 70;
         for (int i = 0; i < 135; i++) begin
            if (i == 60) begin
               // hold the sender until the window has drained its results
               req_valid <= 1'b0;
               while (pending_count != 0) @(negedge clock);
            end
            send_random();
         end
      end

      req_valid <= 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("sliding_window_mean_std regression: pass");
      else
         $display("sliding_window_mean_std regression: fail");
      $finish;
   end

endmodule
